// File: rtl/stereo_linear_resampler_assert.svh
// ----------------------------------------------------------------------------
// stereo_linear_resampler assertion macros
// immediate-implication and next-cycle checks, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef STEREO_LINEAR_RESAMPLER_ASSERT_SVH
`define STEREO_LINEAR_RESAMPLER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SLR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slr assertion failed");

// consequent must hold in the cycle after the antecedent
`define SLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slr assertion failed");

`endif

// File: rtl/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// shared constants and sequencer states for the stereo linear resampler
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 12;
  localparam int STEP_BITS   = 15;
  localparam int STEP_RESET  = 4096;
  localparam int MAX_RUN     = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_R,
    ST_EMIT
  } slr_state_t;

endpackage

// File: rtl/slr_stream_if.sv
// ----------------------------------------------------------------------------
// slr stream interfaces
// valid/ready channels for source frames and interpolated frames
// ----------------------------------------------------------------------------
interface slr_in_if #(
  parameter int SAMPLE_BITS = slr_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface slr_out_if #(
  parameter int SAMPLE_BITS = slr_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          last_in_run;

  modport source (output valid, output left_out, output right_out,
                  output last_in_run, input ready);
  modport sink (input valid, input left_out, input right_out,
                input last_in_run, output ready);
endinterface

// File: rtl/slr_blend.sv
// ----------------------------------------------------------------------------
// slr_blend
// shared interpolation unit: registered (b - a) * p, then a + product, rounded
// ----------------------------------------------------------------------------
module slr_blend #(
  parameter int SAMPLE_BITS = slr_pkg::SAMPLE_BITS,
  parameter int FRAC_BITS   = slr_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] a,
  input  logic signed [SAMPLE_BITS-1:0] b,
  input  logic        [FRAC_BITS-1:0]   p,
  output logic signed [SAMPLE_BITS-1:0] y
);

  localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     p_s;
  logic signed [PW-1:0]          prod_c;
  logic signed [PW-1:0]          prod;
  logic signed [SAMPLE_BITS-1:0] a_q;
  logic signed [PW-1:0]          a_ext;
  logic signed [PW-1:0]          sum;

  assign diff   = $signed({b[SAMPLE_BITS-1], b}) - $signed({a[SAMPLE_BITS-1], a});
  assign p_s    = $signed({1'b0, p});
  assign prod_c = diff * p_s;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_c;
      a_q  <= a;
    end
  end

  // a*one + (b-a)*p + one/2, floor shift; always lands between a and b
  assign a_ext = $signed({{2{a_q[SAMPLE_BITS-1]}}, a_q, {FRAC_BITS{1'b0}}});
  assign sum   = a_ext + prod + HALF;
  assign y     = sum[FRAC_BITS +: SAMPLE_BITS];

endmodule

// File: rtl/stereo_linear_resampler.sv
// ----------------------------------------------------------------------------
// stereo_linear_resampler
// pitch shifter: resamples a stereo stream by linear interpolation
// ----------------------------------------------------------------------------
// in_frame carries one source frame (left_in, right_in) per transfer; out_frame
// carries interpolated frames, last_in_run marking the final one caused by
// the current source frame. wr_en/wr_data write pitch_step (unsigned Q3.12,
// values below one/64 are stored as one/64); write only while idle.
// Each result passes through ST_MUL_L, where the shared multiplier forms the
// left product, ST_MUL_R, where it forms the right product, and ST_EMIT,
// which rounds, loads the output register and steps the phase. A frame
// gives at most 64 results. The first frame after reset only primes the
// stored frame; a frame arriving with the phase at or above one gives no
// result. in_frame.ready is high only between runs. If out_frame stalls, a
// finished result waits in the output register and the sequencer holds
// before loading the next one; a new source frame may still be taken while
// the last result of the previous run waits. Reset clears phase, stored
// frame and primed flag, and sets pitch_step to 1.0.
// ----------------------------------------------------------------------------
`include "stereo_linear_resampler_assert.svh"

module stereo_linear_resampler #(
  parameter int SAMPLE_BITS = slr_pkg::SAMPLE_BITS,
  parameter int FRAC_BITS   = slr_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [slr_pkg::STEP_BITS-1:0] wr_data,
  slr_in_if.sink                        in_frame,
  slr_out_if.source                     out_frame
);

  localparam int STEP_BITS = slr_pkg::STEP_BITS;
  localparam int PHASE_W   = ((FRAC_BITS > STEP_BITS) ? FRAC_BITS : STEP_BITS) + 1;
  localparam int RUN_W     = $clog2(slr_pkg::MAX_RUN);
  localparam logic [PHASE_W-1:0]   PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
  localparam logic [STEP_BITS-1:0] MIN_STEP  = STEP_BITS'(1) << (FRAC_BITS - 6);
  localparam logic [STEP_BITS-1:0] STEP_DEF  = STEP_BITS'(slr_pkg::STEP_RESET);
  localparam logic [STEP_BITS-1:0] STEP_INIT = (STEP_DEF < MIN_STEP) ? MIN_STEP : STEP_DEF;
  localparam logic [RUN_W-1:0]     RUN_LAST  = RUN_W'(slr_pkg::MAX_RUN - 1);

  slr_pkg::slr_state_t state, state_next;

  logic [STEP_BITS-1:0]          pitch_step;
  logic                          primed;
  logic signed [SAMPLE_BITS-1:0] prev_l, prev_r, cur_l, cur_r;
  logic [PHASE_W-1:0]            phase;
  logic [RUN_W-1:0]              run_cnt;
  logic signed [SAMPLE_BITS-1:0] left_hold;

  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_left, out_right;
  logic                          out_last;

  logic                          in_accept;
  logic                          out_free;
  logic                          emit_load;
  logic                          emit_last;
  logic                          blend_en;
  logic [PHASE_W-1:0]            phase_sum;
  logic                          phase_ge_one;
  logic                          sum_ge_one;
  logic signed [SAMPLE_BITS-1:0] blend_a, blend_b, blend_y;

  assign out_free     = !out_valid || out_frame.ready;
  assign phase_sum    = phase + PHASE_W'(pitch_step);
  assign phase_ge_one = phase >= PHASE_ONE;
  assign sum_ge_one   = phase_sum >= PHASE_ONE;
  assign emit_last    = sum_ge_one || (run_cnt == RUN_LAST);
  assign in_accept    = in_frame.valid && in_frame.ready;

  // sequencer
  always_comb begin
    state_next     = state;
    in_frame.ready = 1'b0;
    emit_load      = 1'b0;
    blend_en       = 1'b0;
    case (state)
      slr_pkg::ST_IDLE: begin
        in_frame.ready = 1'b1;
        if (in_frame.valid && primed && !phase_ge_one) begin
          state_next = slr_pkg::ST_MUL_L;
        end
      end
      slr_pkg::ST_MUL_L: begin
        blend_en   = 1'b1;
        state_next = slr_pkg::ST_MUL_R;
      end
      slr_pkg::ST_MUL_R: begin
        blend_en   = 1'b1;
        state_next = slr_pkg::ST_EMIT;
      end
      slr_pkg::ST_EMIT: begin
        if (out_free) begin
          emit_load  = 1'b1;
          state_next = emit_last ? slr_pkg::ST_IDLE : slr_pkg::ST_MUL_L;
        end
      end
      default: begin
        state_next = slr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // left channel in the first multiply cycle, right in the second
  assign blend_a = (state == slr_pkg::ST_MUL_L) ? prev_l : prev_r;
  assign blend_b = (state == slr_pkg::ST_MUL_L) ? cur_l : cur_r;

  slr_blend #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_blend (
    .clk (clk),
    .en  (blend_en),
    .a   (blend_a),
    .b   (blend_b),
    .p   (phase[FRAC_BITS-1:0]),
    .y   (blend_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_step <= STEP_INIT;
      primed     <= 1'b0;
      prev_l     <= '0;
      prev_r     <= '0;
      phase      <= '0;
      run_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        pitch_step <= (wr_data < MIN_STEP) ? MIN_STEP : wr_data;
      end

      if (in_accept) begin
        cur_l   <= in_frame.left_in;
        cur_r   <= in_frame.right_in;
        run_cnt <= '0;
        if (!primed) begin
          primed <= 1'b1;
          prev_l <= in_frame.left_in;
          prev_r <= in_frame.right_in;
        end else if (phase_ge_one) begin
          phase  <= phase - PHASE_ONE;
          prev_l <= in_frame.left_in;
          prev_r <= in_frame.right_in;
        end
      end

      if (state == slr_pkg::ST_MUL_R) begin
        left_hold <= blend_y;
      end

      if (emit_load) begin
        if (emit_last) begin
          phase  <= sum_ge_one ? (phase_sum - PHASE_ONE) : '0;
          prev_l <= cur_l;
          prev_r <= cur_r;
        end else begin
          phase   <= phase_sum;
          run_cnt <= run_cnt + RUN_W'(1);
        end
      end

      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_frame.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_left  <= left_hold;
      out_right <= blend_y;
      out_last  <= emit_last;
    end
  end

  assign out_frame.valid       = out_valid;
  assign out_frame.left_out    = out_left;
  assign out_frame.right_out   = out_right;
  assign out_frame.last_in_run = out_last;

  `SLR_ASSERT_IMPL(a_run_phase_below_one, state == slr_pkg::ST_MUL_L, phase < PHASE_ONE)
  `SLR_ASSERT_NEXT(a_prime_no_run, in_accept && !primed, state == slr_pkg::ST_IDLE)
  `SLR_ASSERT_NEXT(a_last_ends_run, emit_load && emit_last, state == slr_pkg::ST_IDLE)
  `SLR_ASSERT_NEXT(a_emit_fills_out, emit_load, out_valid && (out_last == $past(emit_last)))

endmodule

// File: test/stereo_linear_resampler_tb.sv
// ----------------------------------------------------------------------------
// stereo_linear_resampler_tb
// feeds source frames through the valid/ready channels under several pitch
// steps, predicts each interpolated frame and checks the output stream in order
// ----------------------------------------------------------------------------
module stereo_linear_resampler_tb;

  localparam int SAMPLE_BITS = slr_pkg::SAMPLE_BITS;
  localparam int FRAC_BITS   = slr_pkg::FRAC_BITS;
  localparam int STEP_BITS   = slr_pkg::STEP_BITS;
  localparam int MAX_RUN     = slr_pkg::MAX_RUN;
  localparam int STEP_RESET  = slr_pkg::STEP_RESET;
  localparam int PHASE_ONE   = 1 << FRAC_BITS;
  localparam int MIN_STEP    = PHASE_ONE >> 6;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } src_frame_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          last;
  } interp_frame_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 wr_en;
  logic [STEP_BITS-1:0] wr_data;

  slr_in_if  in_if ();
  slr_out_if out_if ();

  stereo_linear_resampler dut (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_data   (wr_data),
    .in_frame  (in_if),
    .out_frame (out_if)
  );

  always #4 clk = ~clk;

  // predictor state
  logic signed [SAMPLE_BITS-1:0] prev_l = '0;
  logic signed [SAMPLE_BITS-1:0] prev_r = '0;
  int unsigned                   phase_acc = 0;
  int unsigned                   step_now;
  bit                            primed = 1'b0;

  src_frame_t    src_frames[$];
  interp_frame_t interp_due[$];
  src_frame_t    offered;

  bit idle_on = 1'b1;
  int src_gap = 0;
  int snk_gap = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int results_seen = 0;
  int mismatches = 0;
  int cycles = 0;

  // rounding half up, floor of the shifted sum
  function automatic logic signed [SAMPLE_BITS-1:0] mix_sample(longint a, longint b,
                                                               longint p);
    longint acc;
    acc = a * (PHASE_ONE - p) + b * p + (PHASE_ONE >> 1);
    return SAMPLE_BITS'(acc >>> FRAC_BITS);
  endfunction

  function automatic void interpolate_frame(logic signed [SAMPLE_BITS-1:0] l,
                                            logic signed [SAMPLE_BITS-1:0] r);
    interp_frame_t f;
    int            n;
    if (!primed) begin
      primed = 1'b1;
      prev_l = l;
      prev_r = r;
      return;
    end
    n = 0;
    while (phase_acc < PHASE_ONE && n < MAX_RUN) begin
      f.left  = mix_sample(prev_l, l, phase_acc);
      f.right = mix_sample(prev_r, r, phase_acc);
      f.last  = (phase_acc + step_now >= PHASE_ONE) || (n == MAX_RUN - 1);
      interp_due.push_back(f);
      phase_acc += step_now;
      n++;
    end
    if (phase_acc >= PHASE_ONE) phase_acc -= PHASE_ONE;
    else phase_acc = 0;
    prev_l = l;
    prev_r = r;
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return int'($urandom_range(0, 15)) - 8;
      default: return int'($urandom);
    endcase
  endfunction

  task automatic queue_frame(int l, int r);
    src_frames.push_back('{SAMPLE_BITS'(l), SAMPLE_BITS'(r)});
  endtask

  // wait for every frame to be taken and every result to come back
  task automatic settle();
    while (src_frames.size() != 0 || in_if.valid || interp_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_step(int v);
    wr_en   <= 1'b1;
    wr_data <= STEP_BITS'(v);
    step_now = (v < MIN_STEP) ? MIN_STEP : v;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // source side
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        interpolate_frame(offered.left, offered.right);
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (src_frames.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
          src_gap = $urandom_range(0, 4);
          in_if.valid <= 1'b0;
        end else begin
          offered = src_frames.pop_front();
          in_if.left_in  <= offered.left;
          in_if.right_in <= offered.right;
          in_if.valid    <= 1'b1;
        end
      end
    end
  end

  // one long hold while the source keeps offering, so the input stalls
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && results_seen >= 150 && src_frames.size() > 4) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD;
    end
  end

  // result side
  always @(posedge clk) begin
    interp_frame_t got;
    interp_frame_t want;
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.left_out, out_if.right_out, out_if.last_in_run};
        results_seen++;
        if (interp_due.size() == 0) begin
          $display("%0t: expected no transfer, got left %0d right %0d last %0b",
                   $time, got.left, got.right, got.last);
          mismatches++;
        end else begin
          want = interp_due.pop_front();
          if (got !== want) begin
            $display("%0t: expected l %0d r %0d last %0b, got l %0d r %0d last %0b",
                     $time, want.left, want.right, want.last, got.left, got.right, got.last);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        snk_gap = $urandom_range(0, 4);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int total;
    int n_items;
    rst            = 1'b1;
    wr_en          = 1'b0;
    wr_data        = '0;
    step_now       = STEP_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset step of one: priming frame, then sample extremes
    queue_frame(-32768, 32767);
    queue_frame(32767, -32768);
    queue_frame(0, 0);
    queue_frame(-1, 1);
    queue_frame(32767, 32767);
    queue_frame(-32768, -32768);
    settle();

    // zero is clamped up to the minimum step: full runs of results
    write_step(0);
    queue_frame(32767, -32768);
    queue_frame(-32768, 32767);
    settle();
    write_step(MIN_STEP - 1);
    queue_frame(12345, -54);
    settle();

    // largest step: phase stays above one for several frames
    write_step((1 << STEP_BITS) - 1);
    repeat (7) queue_frame(pick_sample(), pick_sample());
    settle();

    // step change with the phase part way through
    write_step(2000);
    repeat (3) queue_frame(pick_sample(), pick_sample());
    settle();

    total = 0;
    while (total < 500) begin
      case ($urandom_range(0, 9))
        0: begin
          write_step($urandom_range(MIN_STEP, 200));
          n_items = $urandom_range(2, 5);
        end
        1: begin
          write_step($urandom_range(0, MIN_STEP - 1));
          n_items = $urandom_range(1, 3);
        end
        2: begin
          write_step($urandom_range(8192, 32767));
          n_items = $urandom_range(15, 40);
        end
        default: begin
          write_step($urandom_range(1024, 8192));
          n_items = $urandom_range(20, 50);
        end
      endcase
      // last stretch runs with no idling on either side
      if (total > 420) idle_on = 1'b0;
      repeat (n_items) queue_frame(pick_sample(), pick_sample());
      total += n_items;
      settle();
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/slr_pkg.sv
rtl/slr_stream_if.sv
rtl/slr_blend.sv
rtl/stereo_linear_resampler.sv
test/stereo_linear_resampler_tb.sv
